/* rtl/core/dwf_pkg.sv */
// Shared types, defaults and helpers for the distinct word filter.
`default_nettype none

package dwf_pkg;

  localparam int MAX_CHARS_DEF   = 32;
  localparam int TABLE_DEPTH_DEF = 256;

  typedef enum logic [1:0] {
    ST_ACCEPT,
    ST_SCAN,
    ST_FINISH
  } dwf_state_t;

  // compare token handed from cell to cell
  typedef struct packed {
    logic valid;
    logic match;
  } dwf_tok_t;

  function automatic logic [7:0] fold_case(input logic [7:0] c);
    logic [7:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) begin
      r = c + 8'h20;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/dwf_cell.sv */
// One character column: buffered char, stored column of all slots, compare stage.
`default_nettype none

module dwf_cell #(
  parameter int IDX         = 0,
  parameter int MAX_CHARS   = dwf_pkg::MAX_CHARS_DEF,
  parameter int TABLE_DEPTH = dwf_pkg::TABLE_DEPTH_DEF,
  parameter int LW          = $clog2(MAX_CHARS + 1),
  parameter int SW          = $clog2(TABLE_DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             flush,
  input  wire logic             char_we,
  input  wire logic [7:0]       char_in,
  input  wire logic [LW-1:0]    word_len,
  input  wire logic             store_we,
  input  wire logic [SW-1:0]    store_addr,
  input  wire dwf_pkg::dwf_tok_t in_tok,
  input  wire logic [SW-1:0]    in_slot,
  output dwf_pkg::dwf_tok_t     out_tok,
  output logic      [SW-1:0]    out_slot
);
  import dwf_pkg::*;

  logic [7:0]    column [TABLE_DEPTH];
  logic [7:0]    ch;
  logic [7:0]    rdata;
  dwf_tok_t      mid_tok;
  logic [SW-1:0] mid_slot;
  logic          active;

  // positions at or past the word length take no part in the compare
  assign active = word_len > LW'(IDX);

  always_ff @(posedge clk) begin
    if (char_we) begin
      ch <= char_in;
    end
  end

  always_ff @(posedge clk) begin
    if (store_we) begin
      column[store_addr] <= ch;
    end
    rdata <= column[in_slot];
  end

  always_ff @(posedge clk) begin
    if (rst || flush) begin
      mid_tok.valid <= 1'b0;
      out_tok.valid <= 1'b0;
    end else begin
      mid_tok.valid <= in_tok.valid;
      out_tok.valid <= mid_tok.valid;
    end
    mid_tok.match <= in_tok.match;
    mid_slot      <= in_slot;
    out_tok.match <= mid_tok.match & (!active || rdata == ch);
    out_slot      <= mid_slot;
  end

endmodule

`default_nettype wire

/* rtl/core/distinct_word_filter.sv */
// Top level: character intake, length store, scan control and result register.
// Characters are taken one beat per cycle while in the accept state; the beat carrying tlast
// starts a scan. Scan: stored slots enter the cell chain one per cycle; the scan ends at the
// first match, when the last stored slot leaves the chain without one, or at once when
// nothing is stored. The result is registered once the output register is free.
// Synchronous active-high reset empties the table and the current word.
`default_nettype none

module distinct_word_filter #(
  parameter int MAX_CHARS   = dwf_pkg::MAX_CHARS_DEF,
  parameter int TABLE_DEPTH = dwf_pkg::TABLE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [7:0]  s_tdata,   // [7:0] character
  input  wire logic        s_tlast,   // last
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [23:0]      m_tdata,   // [7:0] entry_index, [16:8] unique_count, zero pad
  output logic [2:0]       m_tuser    // [0] is_new, [1] table_full, [2] word_truncated
);
  import dwf_pkg::*;

  localparam int LW = $clog2(MAX_CHARS + 1);
  localparam int SW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  dwf_state_t    state, state_next;
  logic [LW-1:0] word_len;
  logic          trunc;
  logic [CW-1:0] count;
  logic [CW-1:0] issue;
  logic          head_valid;
  logic [SW-1:0] head_slot;
  logic [LW-1:0] len_mem [TABLE_DEPTH];
  logic [LW-1:0] len_rdata;
  logic          found;
  logic [SW-1:0] found_slot;

  logic          accept;
  logic          char_fire;
  logic [7:0]    folded;
  logic          issue_fire;
  logic          hit;
  logic          miss_end;
  logic          flush;
  logic          commit;
  logic          room;
  logic          insert;
  logic [CW-1:0] res_index;
  logic [CW-1:0] res_count;

  logic          out_new;
  logic          out_full;
  logic          out_trunc;
  logic [7:0]    out_index;
  logic [8:0]    out_count;

  dwf_tok_t      chain_tok  [MAX_CHARS+1];
  logic [SW-1:0] chain_slot [MAX_CHARS+1];
  logic [MAX_CHARS-1:0] cell_we;

  assign s_tready  = (state == ST_ACCEPT);
  assign accept    = s_tvalid && s_tready;
  assign folded    = fold_case(s_tdata);
  assign char_fire = accept && (word_len < LW'(MAX_CHARS));

  assign issue_fire = (state == ST_SCAN) && (issue < count);
  assign hit        = (state == ST_SCAN) && chain_tok[MAX_CHARS].valid
                      && chain_tok[MAX_CHARS].match;
  // last issued slot came out without a match
  assign miss_end   = (state == ST_SCAN) && chain_tok[MAX_CHARS].valid
                      && !chain_tok[MAX_CHARS].match
                      && (CW'(chain_slot[MAX_CHARS]) + CW'(1) == count);
  assign room       = count < CW'(TABLE_DEPTH);
  assign insert     = commit && !found && room;

  always_comb begin
    state_next = state;
    flush      = 1'b0;
    commit     = 1'b0;
    unique case (state)
      ST_ACCEPT: begin
        if (accept && s_tlast) begin
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (count == '0 || hit || miss_end) begin
          state_next = ST_FINISH;
          flush      = 1'b1;
        end
      end
      ST_FINISH: begin
        if (!m_tvalid || m_tready) begin
          commit     = 1'b1;
          state_next = ST_ACCEPT;
        end
      end
      default: state_next = ST_ACCEPT;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_ACCEPT;
    end else begin
      state <= state_next;
    end
  end

  // word intake
  always_ff @(posedge clk) begin
    if (rst) begin
      word_len <= '0;
      trunc    <= 1'b0;
    end else if (commit) begin
      word_len <= '0;
      trunc    <= 1'b0;
    end else if (accept) begin
      if (char_fire) begin
        word_len <= word_len + LW'(1);
      end else begin
        trunc <= 1'b1;
      end
    end
  end

  // scan issue and length column
  always_ff @(posedge clk) begin
    if (rst || flush) begin
      head_valid <= 1'b0;
    end else begin
      head_valid <= issue_fire;
    end
    head_slot <= issue[SW-1:0];
    len_rdata <= len_mem[issue[SW-1:0]];
    if (insert) begin
      len_mem[count[SW-1:0]] <= word_len;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      issue <= '0;
      found <= 1'b0;
    end else if (state == ST_ACCEPT) begin
      issue <= '0;
      found <= 1'b0;
    end else begin
      if (issue_fire) begin
        issue <= issue + CW'(1);
      end
      if (hit) begin
        found <= 1'b1;
      end
    end
    if (hit) begin
      found_slot <= chain_slot[MAX_CHARS];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (insert) begin
      count <= count + CW'(1);
    end
  end

  // result register
  always_comb begin
    if (found) begin
      res_index = CW'(found_slot);
    end else if (room) begin
      res_index = count;
    end else begin
      res_index = '0;
    end
    res_count = room && !found ? count + CW'(1) : count;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (commit) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (commit) begin
      out_new   <= !found && room;
      out_full  <= !found && !room;
      out_trunc <= trunc;
      out_index <= 8'(res_index);
      out_count <= 9'(res_count);
    end
  end

  assign m_tdata = {7'd0, out_count, out_index};
  assign m_tuser = {out_trunc, out_full, out_new};

  // cell chain
  assign chain_tok[0].valid = head_valid;
  assign chain_tok[0].match = (len_rdata == word_len);
  assign chain_slot[0]      = head_slot;

  for (genvar k = 0; k < MAX_CHARS; k++) begin : g_cell
    assign cell_we[k] = char_fire && (word_len == LW'(k));

    dwf_cell #(
      .IDX         (k),
      .MAX_CHARS   (MAX_CHARS),
      .TABLE_DEPTH (TABLE_DEPTH),
      .LW          (LW),
      .SW          (SW)
    ) u_cell (
      .clk        (clk),
      .rst        (rst),
      .flush      (flush),
      .char_we    (cell_we[k]),
      .char_in    (folded),
      .word_len   (word_len),
      .store_we   (insert),
      .store_addr (count[SW-1:0]),
      .in_tok     (chain_tok[k]),
      .in_slot    (chain_slot[k]),
      .out_tok    (chain_tok[k+1]),
      .out_slot   (chain_slot[k+1])
    );
  end

  // checks
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(TABLE_DEPTH))
    else $error("stored count beyond table depth");

  a_count_step: assert property (@(posedge clk) disable iff (rst)
    ##1 (count == $past(count) || count == $past(count) + CW'(1)))
    else $error("stored count jumped");

  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    word_len <= LW'(MAX_CHARS))
    else $error("word length beyond buffer");

  a_tail_in_range: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && chain_tok[MAX_CHARS].valid)
      |-> CW'(chain_slot[MAX_CHARS]) < count)
    else $error("scan token for an empty slot");

  a_new_full_excl: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(out_new && out_full))
    else $error("result both new and dropped");

endmodule

`default_nettype wire

/* bench/distinct_word_filter_tb.sv */
// Self-checking bench for distinct_word_filter: random words, folded-case repeats, overflow.
module distinct_word_filter_tb;

  localparam int MAX_CHARS   = dwf_pkg::MAX_CHARS_DEF;
  localparam int TABLE_DEPTH = dwf_pkg::TABLE_DEPTH_DEF;
  localparam int MAX_WORD    = MAX_CHARS + 8;      // longest word the stimulus builds
  localparam int HIST_DEPTH  = 2048;
  localparam int RANDOM_BEATS = 1450;
  localparam int QUIET_TAIL  = 120;                // beats left when idling stops
  // worst scan: the whole cell chain plus every stored slot, plus margin
  localparam int SETTLE      = 2 * MAX_CHARS + TABLE_DEPTH + 64;
  localparam int STALL_LIMIT = 10 * SETTLE;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
    logic       drain_first;   // hold this beat until every pending result is back
  } char_beat_t;

  typedef struct packed {
    logic       is_new;
    logic [7:0] entry_index;
    logic [8:0] unique_count;
    logic       table_full;
    logic       word_truncated;
  } word_verdict_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata = 8'h00;
  logic        s_tlast = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [23:0] m_tdata;
  logic [2:0]  m_tuser;

  distinct_word_filter uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser)
  );

  always #5 clk = ~clk;

  char_beat_t    beats[$];
  word_verdict_t expected_words[$];
  int errors = 0;
  int words_sent = 0;
  int results_seen = 0;
  int idle_pct = 15;
  int gap_left = 0;
  int stall_left = 0;
  int idle_cycles = 0;

  // shadow of the word table
  logic [7:0] table_chars [0:TABLE_DEPTH-1][0:MAX_CHARS-1];
  int         table_len [0:TABLE_DEPTH-1];
  int         table_used = 0;
  logic [7:0] cur_chars [0:MAX_CHARS-1];
  int         cur_len = 0;
  bit         cur_cut = 1'b0;

  // words already sent, for repeats
  logic [7:0] hist_chars [0:HIST_DEPTH-1][0:MAX_WORD-1];
  int         hist_len [0:HIST_DEPTH-1];
  int         hist_n = 0;
  logic [7:0] tx_chars [0:MAX_WORD-1];

  task automatic absorb_char(input logic [7:0] raw, input logic is_last);
    logic [7:0]    c;
    word_verdict_t v;
    int            slot;
    bit            hit;
    bit            same;
    c = raw;
    if (c >= 8'h41 && c <= 8'h5A) c = c + 8'h20;
    if (cur_len < MAX_CHARS) begin
      cur_chars[cur_len] = c;
      cur_len++;
    end else begin
      cur_cut = 1'b1;
    end
    if (is_last) begin
      hit = 1'b0;
      slot = 0;
      for (int s = 0; s < table_used && !hit; s++) begin
        if (table_len[s] == cur_len) begin
          same = 1'b1;
          for (int k = 0; k < cur_len; k++)
            if (table_chars[s][k] != cur_chars[k]) same = 1'b0;
          if (same) begin
            hit = 1'b1;
            slot = s;
          end
        end
      end
      v.is_new = 1'b0;
      v.table_full = 1'b0;
      v.entry_index = slot[7:0];
      if (!hit) begin
        if (table_used < TABLE_DEPTH) begin
          for (int k = 0; k < cur_len; k++) table_chars[table_used][k] = cur_chars[k];
          table_len[table_used] = cur_len;
          v.entry_index = table_used[7:0];
          table_used++;
          v.is_new = 1'b1;
        end else begin
          v.entry_index = 8'd0;
          v.table_full = 1'b1;
        end
      end
      v.unique_count = table_used[8:0];
      v.word_truncated = cur_cut;
      expected_words.push_back(v);
      cur_len = 0;
      cur_cut = 1'b0;
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      errors++;
    end
  endtask

  // queues tx_chars[0 .. len-1] as one word and records it for later repeats
  task automatic queue_word(input int len, input bit drain);
    char_beat_t b;
    for (int k = 0; k < len; k++) begin
      b.ch = tx_chars[k];
      b.last = (k == len - 1);
      b.drain_first = drain && (k == 0);
      beats.push_back(b);
    end
    if (hist_n < HIST_DEPTH) begin
      for (int k = 0; k < len; k++) hist_chars[hist_n][k] = tx_chars[k];
      hist_len[hist_n] = len;
      hist_n++;
    end
  endtask

  // up to four characters, first one in the low byte
  task automatic add_directed(input logic [31:0] packed_chars, input int len);
    for (int k = 0; k < len; k++) tx_chars[k] = packed_chars[8*k +: 8];
    queue_word(len, 1'b0);
  endtask

  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    if ($urandom_range(0, 1) == 0) c = 8'($urandom_range(0, 255));
    else if ($urandom_range(0, 1) == 0) c = 8'h61 + 8'($urandom_range(0, 25));
    else c = 8'h41 + 8'($urandom_range(0, 25));
    return c;
  endfunction

  // sender
  always @(posedge clk) begin : drive
    char_beat_t nb;
    if (rst) begin
      s_tvalid <= 1'b0;
      s_tlast <= 1'b0;
    end else begin
      if (s_tvalid && s_tready && s_tlast) begin
        words_sent++;
        if ($urandom_range(99) < 10) begin
          case ($urandom_range(0, 2))
            0: idle_pct = 0;
            1: idle_pct = 15;
            default: idle_pct = 40;
          endcase
        end
      end
      if (!s_tvalid || s_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          s_tvalid <= 1'b0;
        end else if (beats.size() == 0) begin
          s_tvalid <= 1'b0;
        end else if (beats[0].drain_first && words_sent != results_seen) begin
          s_tvalid <= 1'b0;
        end else begin
          nb = beats.pop_front();
          s_tvalid <= 1'b1;
          s_tdata <= nb.ch;
          s_tlast <= nb.last;
          if (beats.size() >= QUIET_TAIL && $urandom_range(99) < idle_pct)
            gap_left = $urandom_range(1, 4);
        end
      end
    end
  end

  // receiver
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
      if (beats.size() >= QUIET_TAIL && $urandom_range(99) < idle_pct)
        stall_left = $urandom_range(1, 4);
    end
  end

  // predict on every accepted char beat, check every accepted result beat
  always @(posedge clk) begin : monitor
    word_verdict_t want;
    if (!rst) begin
      if (s_tvalid && s_tready) absorb_char(s_tdata, s_tlast);
      if (m_tvalid && m_tready) begin
        results_seen++;
        if (expected_words.size() == 0) begin
          $error("result beat with no word pending: tdata=%h tuser=%b", m_tdata, m_tuser);
          errors++;
        end else begin
          want = expected_words.pop_front();
          check_field("is_new", int'(want.is_new), int'(m_tuser[0]));
          check_field("entry_index", int'(want.entry_index), int'(m_tdata[7:0]));
          check_field("unique_count", int'(want.unique_count), int'(m_tdata[16:8]));
          check_field("table_full", int'(want.table_full), int'(m_tuser[1]));
          check_field("word_truncated", int'(want.word_truncated), int'(m_tuser[2]));
        end
      end
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("timeout: no beat moved for %0d cycles", STALL_LIMIT);
        $display("distinct_word_filter_tb: FAIL");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int random_beats;
    int kind;
    int len;
    int pick;
    int directed_words;
    bit drain;
    logic [7:0] c;

    // fold boundaries, extremes, exact-length compare
    add_directed(32'h00, 1);
    add_directed(32'hFF, 1);
    add_directed(32'h5A41, 2);         // "AZ"
    add_directed(32'h7A61, 2);         // "az" must match the folded "AZ"
    add_directed(32'h7B605B40, 4);     // neighbors of both letter ranges, not folded
    add_directed(32'h00, 1);
    add_directed(32'h61, 1);
    add_directed(32'h41, 1);
    add_directed(32'h007A61, 3);       // "az" plus a NUL: longer, so new
    add_directed(32'h7F8042, 3);
    directed_words = hist_n;

    // mostly short fresh words to fill the table, repeats with mixed case,
    // a few words around and past the length limit
    random_beats = 0;
    while (random_beats < RANDOM_BEATS) begin
      kind = $urandom_range(99);
      drain = (hist_n == directed_words) || ($urandom_range(99) < 2);
      if (kind < 3) begin
        len = $urandom_range(MAX_CHARS - 1, MAX_WORD);
        for (int k = 0; k < len; k++) tx_chars[k] = rand_char();
      end else if (kind < 28) begin
        pick = $urandom_range(0, hist_n - 1);
        len = hist_len[pick];
        for (int k = 0; k < len; k++) begin
          c = hist_chars[pick][k];
          if (k >= MAX_CHARS) c = 8'($urandom_range(0, 255));   // dropped tail may differ
          else if ((c | 8'h20) >= 8'h61 && (c | 8'h20) <= 8'h7A)
            c = $urandom_range(0, 1) ? (c | 8'h20) : (c & 8'hDF);
          tx_chars[k] = c;
        end
      end else begin
        len = $urandom_range(1, 3);
        for (int k = 0; k < len; k++) tx_chars[k] = rand_char();
      end
      queue_word(len, drain);
      random_beats += len;
    end

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (beats.size() > 0 || s_tvalid || words_sent != results_seen) @(negedge clk);
    repeat (SETTLE) @(posedge clk);

    if (expected_words.size() != 0) begin
      $error("%0d expected results never arrived", expected_words.size());
      errors++;
    end
    if (errors == 0) $display("distinct_word_filter_tb: PASS");
    else $display("distinct_word_filter_tb: FAIL");
    $finish;
  end

endmodule
